@@ src/qasmp_pkg.sv @@
// Shared types, constants and helpers for the quad ADC slave memory protocol unit.
// No dependencies; imported by the front, queue, back and top-level modules.
package qasmp_pkg;

    localparam int PAGE_BYTES = 8;
    localparam int PAGE_TOTAL = 4;
    localparam int MEM_BYTES  = PAGE_BYTES * PAGE_TOTAL;
    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int CNT_W      = $clog2(PAGE_BYTES);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // highest page start; anything above it wraps to zero
    localparam logic [15:0] LAST_START = 16'((PAGE_TOTAL - 1) * PAGE_BYTES);

    localparam logic [7:0] CMD_READ    = 8'hAA;
    localparam logic [7:0] CMD_WRITE   = 8'h55;
    localparam logic [7:0] CMD_CONVERT = 8'h3C;

    localparam int         INIT_IDX = 'h1C;
    localparam logic [7:0] INIT_VAL = 8'h40;

    localparam logic [1:0] ACT_BUS   = 2'd0;
    localparam logic [1:0] ACT_HOST  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    typedef enum logic [2:0] {
        OP_HOST,   // host channel write: two memory bytes
        OP_CMD,    // command byte: restart CRC with it
        OP_ADD,    // fold byte into CRC only
        OP_READ,   // last address byte, then send one page and the CRC
        OP_WDATA,  // store a data byte; final one sends the CRC
        OP_CONV    // last convert byte, then CRC and two status bits
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [7:0]        data;
        logic [7:0]        hi;
        logic [1:0]        chan;
        logic [ADDR_W-1:0] addr;
        logic              final_byte;
    } t_qent;

    // CRC16, reflected polynomial 0xA001, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 16'hA001;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // content of a memory byte that has never been written
    function automatic logic [7:0] mem_init_byte(input logic [ADDR_W-1:0] idx);
        logic [7:0] v;
        v = 8'h00;
        if ((MEM_BYTES > INIT_IDX) && (int'(idx) == INIT_IDX)) begin
            v = INIT_VAL;
        end
        return v;
    endfunction

endpackage

@@ src/qasmp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependency.
module qasmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/qasmp_queue.sv @@
// Short FIFO of classified operations between the front and back parts.
// Depends on qasmp_pkg for the entry type and depth.
module qasmp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qasmp_pkg::t_qent i_ent,
    output logic             o_full,
    input  logic             i_pop,
    output qasmp_pkg::t_qent o_ent,
    output logic             o_empty
);
    import qasmp_pkg::*;

    t_qent              r_slot [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               push_ok, pop_ok;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_ent   = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push_ok) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop_ok) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wptr] <= i_ent;
        end
    end

endmodule

@@ src/qasmp_front.sv @@
// Front part: accepts input items, tracks the bus transaction phase and
// queues the memory/CRC operations each item implies. Depends on qasmp_pkg.
module qasmp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_bus_byte,
    input  logic [1:0]       i_channel,
    input  logic [15:0]      i_channel_value,
    output logic             o_push,
    output qasmp_pkg::t_qent o_ent,
    input  logic             i_full
);
    import qasmp_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b000_0001,
        PH_CMD     = 7'b000_0010,
        PH_ADDR_LO = 7'b000_0100,
        PH_ADDR_HI = 7'b000_1000,
        PH_WDATA   = 7'b001_0000,
        PH_CONV1   = 7'b010_0000,
        PH_CONV2   = 7'b100_0000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic              r_is_read, n_is_read;
    logic [7:0]        r_addr_lo, n_addr_lo;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              accept;
    logic [15:0]       full_addr;
    logic [ADDR_W-1:0] page_addr;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign full_addr  = {i_bus_byte, r_addr_lo};
    assign page_addr  = (full_addr > LAST_START) ? '0 : full_addr[ADDR_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_is_read = r_is_read;
        n_addr_lo = r_addr_lo;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        o_push    = 1'b0;
        o_ent.op         = OP_ADD;
        o_ent.data       = i_bus_byte;
        o_ent.hi         = i_channel_value[15:8];
        o_ent.chan       = i_channel;
        o_ent.addr       = r_addr + ADDR_W'(r_cnt);
        o_ent.final_byte = (r_cnt == CNT_W'(PAGE_BYTES - 1));

        if (accept) begin
            unique case (i_action)
                ACT_HOST: begin
                    o_push     = 1'b1;
                    o_ent.op   = OP_HOST;
                    o_ent.data = i_channel_value[7:0];
                end
                ACT_START: begin
                    n_phase = PH_CMD;
                end
                ACT_BUS: begin
                    unique case (r_phase)
                        PH_CMD: begin
                            o_ent.op = OP_CMD;
                            if (i_bus_byte == CMD_READ || i_bus_byte == CMD_WRITE) begin
                                o_push    = 1'b1;
                                n_is_read = (i_bus_byte == CMD_READ);
                                n_phase   = PH_ADDR_LO;
                            end else if (i_bus_byte == CMD_CONVERT) begin
                                o_push  = 1'b1;
                                n_phase = PH_CONV1;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_ADDR_LO: begin
                            o_push    = 1'b1;
                            n_addr_lo = i_bus_byte;
                            n_phase   = PH_ADDR_HI;
                        end
                        PH_ADDR_HI: begin
                            o_push     = 1'b1;
                            o_ent.addr = page_addr;
                            if (r_is_read) begin
                                o_ent.op = OP_READ;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_addr  = page_addr;
                                n_cnt   = '0;
                                n_phase = PH_WDATA;
                            end
                        end
                        PH_WDATA: begin
                            o_push   = 1'b1;
                            o_ent.op = OP_WDATA;
                            if (o_ent.final_byte) begin
                                n_cnt   = '0;
                                n_phase = PH_IDLE;
                            end else begin
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                        PH_CONV1: begin
                            o_push  = 1'b1;
                            n_phase = PH_CONV2;
                        end
                        PH_CONV2: begin
                            o_push   = 1'b1;
                            o_ent.op = OP_CONV;
                            n_phase  = PH_IDLE;
                        end
                        default: begin
                            // idle: drop stray bus bytes
                        end
                    endcase
                end
                default: begin
                    // unused action code: drop
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_read <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_is_read <= n_is_read;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_lo <= n_addr_lo;
        r_addr    <= n_addr;
    end

endmodule

@@ src/qasmp_back.sv @@
// Back part: carries out queued operations on the byte memory and the CRC,
// and drives the registered result channel. Depends on qasmp_pkg, qasmp_ram.
module qasmp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qasmp_pkg::t_qent i_ent,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_kind,
    output logic [7:0]       o_out_value,
    output logic             o_last
);
    import qasmp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_HOST_HI = 8'b0000_0010,
        S_RD_ADDR = 8'b0000_0100,
        S_RD_DATA = 8'b0000_1000,
        S_CRC_LO  = 8'b0001_0000,
        S_CRC_HI  = 8'b0010_0000,
        S_BIT0    = 8'b0100_0000,
        S_BIT1    = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    t_qent             r_ent, n_ent;
    logic [15:0]       r_crc, n_crc;
    logic              r_conv, n_conv;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MEM_BYTES-1:0] r_vld;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_ovalid, n_ovalid;
    logic              r_okind, n_okind;
    logic [7:0]        r_oval, n_oval;
    logic              r_olast, n_olast;

    logic              out_free;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data, rd_byte;
    logic [2:0]        hi_pos;

    assign out_free = !r_ovalid || i_out_ready;
    assign hi_pos   = {r_ent.chan, 1'b1};
    assign rd_addr  = r_ent.addr + ADDR_W'(r_cnt);
    assign rd_en    = (r_state == S_RD_ADDR);
    assign rd_byte  = r_rd_vld ? rd_data : mem_init_byte(r_rd_idx);

    qasmp_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state  = r_state;
        n_ent    = r_ent;
        n_crc    = r_crc;
        n_conv   = r_conv;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        n_okind  = r_okind;
        n_oval   = r_oval;
        n_olast  = r_olast;
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = i_ent.addr;
        wr_data  = i_ent.data;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_ent = i_ent;
                    unique case (i_ent.op)
                        OP_HOST: begin
                            wr_en   = (int'({i_ent.chan, 1'b0}) < MEM_BYTES);
                            wr_addr = ADDR_W'({i_ent.chan, 1'b0});
                            n_state = S_HOST_HI;
                        end
                        OP_CMD: begin
                            n_crc = crc_byte(16'h0000, i_ent.data);
                        end
                        OP_READ: begin
                            n_crc   = crc_byte(r_crc, i_ent.data);
                            n_cnt   = '0;
                            n_state = S_RD_ADDR;
                        end
                        OP_WDATA: begin
                            wr_en = 1'b1;
                            n_crc = crc_byte(r_crc, i_ent.data);
                            if (i_ent.final_byte) begin
                                n_conv  = 1'b0;
                                n_state = S_CRC_LO;
                            end
                        end
                        OP_CONV: begin
                            n_crc   = crc_byte(r_crc, i_ent.data);
                            n_conv  = 1'b1;
                            n_state = S_CRC_LO;
                        end
                        default: begin
                            n_crc = crc_byte(r_crc, i_ent.data);
                        end
                    endcase
                end
            end
            S_HOST_HI: begin
                wr_en   = (int'(hi_pos) < MEM_BYTES);
                wr_addr = ADDR_W'(hi_pos);
                wr_data = r_ent.hi;
                n_state = S_IDLE;
            end
            S_RD_ADDR: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = 1'b0;
                    n_oval   = rd_byte;
                    n_olast  = 1'b0;
                    n_crc    = crc_byte(r_crc, rd_byte);
                    if (r_cnt == CNT_W'(PAGE_BYTES - 1)) begin
                        n_conv  = 1'b0;
                        n_state = S_CRC_LO;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_RD_ADDR;
                    end
                end
            end
            S_CRC_LO: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = 1'b0;
                    n_oval   = ~r_crc[7:0];
                    n_olast  = 1'b0;
                    n_state  = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = 1'b0;
                    n_oval   = ~r_crc[15:8];
                    n_olast  = !r_conv;
                    n_state  = r_conv ? S_BIT0 : S_IDLE;
                end
            end
            S_BIT0: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = 1'b1;
                    n_oval   = 8'h00;
                    n_olast  = 1'b0;
                    n_state  = S_BIT1;
                end
            end
            S_BIT1: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = 1'b1;
                    n_oval   = 8'h01;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_crc    <= '0;
            r_conv   <= 1'b0;
            r_cnt    <= '0;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_crc    <= n_crc;
            r_conv   <= n_conv;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_okind <= n_okind;
        r_oval  <= n_oval;
        r_olast <= n_olast;
        // hold the written flag of the byte being read, beside its data
        if (rd_en) begin
            r_rd_vld <= r_vld[rd_addr];
            r_rd_idx <= rd_addr;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_out_value = r_oval;
    assign o_last      = r_olast;

endmodule

@@ src/quad_adc_slave_memory_protocol_unit.sv @@
// Quad ADC bus slave: 32-byte paged memory with read, write and convert
// commands, each closed by the inverted CRC16 of the command's traffic.
// Every input item is taken while the two-entry operation queue has room;
// items that cause no result (start, stray or unknown bytes) are dropped at
// once, address and convert bytes are folded into the CRC straight from the
// queue, a host channel write needs a further state for its high byte (one
// memory write port). Result items leave through an output register at one
// per cycle for CRC bytes and status bits while the receiver is ready; page
// bytes pass an address state and a data state each because of the registered
// memory read. Unwritten memory bytes read as their reset value through
// per-byte written flags, so the block is ready straight after reset with no clearing pass.
// Depends on qasmp_pkg, qasmp_front, qasmp_queue, qasmp_back, qasmp_ram.
module quad_adc_slave_memory_protocol_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_bus_byte,
    input  logic [1:0]  i_channel,
    input  logic [15:0] i_channel_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_out_value,
    output logic        o_last
);
    import qasmp_pkg::*;

    t_qent push_ent, pop_ent;
    logic  push, pop, q_full, q_empty;

    qasmp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_bus_byte      (i_bus_byte),
        .i_channel       (i_channel),
        .i_channel_value (i_channel_value),
        .o_push          (push),
        .o_ent           (push_ent),
        .i_full          (q_full)
    );

    qasmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_ent   (pop_ent),
        .o_empty (q_empty)
    );

    qasmp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent       (pop_ent),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the quad ADC bus slave: a directed table then random transactions,
// all checked against a behavioural model of the slave's memory, command flow and CRC16.
// Depends on qasmp_pkg and quad_adc_slave_memory_protocol_unit.
module testbench;
    import qasmp_pkg::*;

    localparam int          CLK_HALF        = 5;
    localparam int          RESET_CYCLES    = 9;
    localparam int          ITEMS_TARGET    = 310;
    localparam int          HOLD_OFF_AT     = 110;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          FLOOD_ITEMS     = 48;
    localparam int          DRAIN_LIMIT     = 20000;
    localparam int          TAIL_CYCLES     = 64;
    localparam int          MAX_PRINTED     = 40;
    localparam int          DIR_ROWS        = 28;
    localparam logic [1:0]  ACT_NONE        = 2'd3;
    localparam logic        KIND_BYTE       = 1'b0;
    localparam logic        KIND_BIT        = 1'b1;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    typedef enum logic [6:0] {
        SP_IDLE    = 7'b000_0001,
        SP_CMD     = 7'b000_0010,
        SP_ADDR_LO = 7'b000_0100,
        SP_ADDR_HI = 7'b000_1000,
        SP_WDATA   = 7'b001_0000,
        SP_CONV1   = 7'b010_0000,
        SP_CONV2   = 7'b100_0000
    } t_slave_phase;

    typedef enum logic [1:0] {SL_NONE, SL_READ, SL_WRITE, SL_CONVERT} t_slave_cmd;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } t_slave_res;

    typedef struct packed {
        logic [1:0]  act;
        logic [7:0]  bus_b;
        logic [1:0]  chan;
        logic [15:0] chval;
        logic [3:0]  n_exp;
        logic        first_typed;
        logic [7:0]  first_val;
    } t_stim_row;

    // Directed sequence; result counts are typed for every row, the first byte where obvious
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{ACT_NONE,  8'hFF,       2'd3, 16'hFFFF, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'hFF,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_HOST,  8'h00,       2'd0, 16'hFFFF, 4'd0,  1'b0, 8'h00},
        '{ACT_START, 8'h00,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   CMD_READ,    2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'hFF,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'hFF,       2'd0, 16'h0000, 4'd10, 1'b1, 8'hFF},
        '{ACT_START, 8'hFF,       2'd3, 16'hFFFF, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   CMD_CONVERT, 2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h00,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'hFF,       2'd0, 16'h0000, 4'd4,  1'b0, 8'h00},
        '{ACT_START, 8'h00,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   CMD_WRITE,   2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_START, 8'h00,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h07,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_START, 8'h00,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   CMD_WRITE,   2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h18,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h00,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h00,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'hFF,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h5A,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'hA5,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_HOST,  8'hFF,       2'd3, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h01,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h80,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'h7F,       2'd0, 16'h0000, 4'd0,  1'b0, 8'h00},
        '{ACT_BUS,   8'hFF,       2'd0, 16'h0000, 4'd2,  1'b0, 8'h00}
    };

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_action        = ACT_BUS;
    logic [7:0]  i_bus_byte      = 8'h00;
    logic [1:0]  i_channel       = 2'd0;
    logic [15:0] i_channel_value = 16'h0000;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_kind;
    logic [7:0]  o_out_value;
    logic        o_last;

    // model of the slave
    t_slave_phase sl_phase = SP_IDLE;
    t_slave_cmd   sl_cmd   = SL_NONE;
    logic [15:0]  sl_addr  = 16'h0000;
    logic [3:0]   sl_count = 4'd0;
    logic [15:0]  sl_crc   = 16'h0000;
    logic [7:0]   sl_mem [MEM_BYTES];

    t_slave_res res_batch [$];
    t_slave_res expected_results [$];
    t_slave_res want;

    logic        in_take         = 1'b0;
    int          errors          = 0;
    int          results_checked = 0;
    int          items_offered   = 0;
    int          items_counted   = 0;
    int          reads_done      = 0;
    int          writes_done     = 0;
    int          converts_done   = 0;
    int          burst_left      = 0;
    int          flood_left      = 0;
    int          hold_off_asked  = 0;
    int          hold_off_given  = 0;
    int          rx_hold_left    = 0;
    logic [31:0] rx_cycle        = 32'd0;

    quad_adc_slave_memory_protocol_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_bus_byte      (i_bus_byte),
        .i_channel       (i_channel),
        .i_channel_value (i_channel_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_out_value     (o_out_value),
        .o_last          (o_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        if (errors < MAX_PRINTED) begin
            $display("%0t ns  mismatch: %s", $time, msg);
        end
        errors++;
    endtask

    // bit-serial CRC16, LSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic add_result(input logic kind, input logic [7:0] val);
        res_batch.push_back('{kind: kind, value: val, last: 1'b0});
    endtask

    task automatic queue_crc;
        add_result(KIND_BYTE, ~sl_crc[7:0]);
        add_result(KIND_BYTE, ~sl_crc[15:8]);
    endtask

    // Advance the model by one accepted item and queue the results it causes
    task automatic predict_slave(input logic [1:0] act, input logic [7:0] bb,
                                 input logic [1:0] ch, input logic [15:0] cv,
                                 output int n_out, output logic [7:0] first_out);
        logic [7:0] d;
        res_batch.delete();
        if (act == ACT_HOST) begin
            sl_mem[2 * int'(ch)]     = cv[7:0];
            sl_mem[2 * int'(ch) + 1] = cv[15:8];
        end else if (act == ACT_START) begin
            sl_phase = SP_CMD;
            sl_cmd   = SL_NONE;
            sl_count = 4'd0;
            sl_crc   = 16'h0000;
        end else if (act == ACT_BUS) begin
            unique case (sl_phase)
                SP_CMD: begin
                    sl_crc   = 16'h0000;
                    sl_count = 4'd0;
                    if (bb == CMD_READ || bb == CMD_WRITE) begin
                        sl_cmd   = (bb == CMD_READ) ? SL_READ : SL_WRITE;
                        sl_phase = SP_ADDR_LO;
                        sl_crc   = crc_fold(sl_crc, bb);
                    end else if (bb == CMD_CONVERT) begin
                        sl_cmd   = SL_CONVERT;
                        sl_phase = SP_CONV1;
                        sl_crc   = crc_fold(sl_crc, bb);
                    end else begin
                        // unknown command: drop back to idle silently
                        sl_cmd   = SL_NONE;
                        sl_phase = SP_IDLE;
                    end
                end
                SP_ADDR_LO: begin
                    sl_addr  = {8'h00, bb};
                    sl_crc   = crc_fold(sl_crc, bb);
                    sl_phase = SP_ADDR_HI;
                end
                SP_ADDR_HI: begin
                    sl_addr = {bb, sl_addr[7:0]};
                    sl_crc  = crc_fold(sl_crc, bb);
                    if (sl_addr > LAST_START) begin
                        sl_addr = 16'h0000;
                    end
                    if (sl_cmd == SL_READ) begin
                        for (int i = 0; i < PAGE_BYTES; i++) begin
                            d = sl_mem[(int'(sl_addr) + i) % MEM_BYTES];
                            add_result(KIND_BYTE, d);
                            sl_crc = crc_fold(sl_crc, d);
                        end
                        queue_crc();
                        sl_phase = SP_IDLE;
                        sl_cmd   = SL_NONE;
                        reads_done++;
                    end else begin
                        sl_count = 4'd0;
                        sl_phase = SP_WDATA;
                    end
                end
                SP_WDATA: begin
                    sl_mem[(int'(sl_addr) + int'(sl_count)) % MEM_BYTES] = bb;
                    sl_crc = crc_fold(sl_crc, bb);
                    if (int'(sl_count) + 1 >= PAGE_BYTES) begin
                        queue_crc();
                        sl_phase = SP_IDLE;
                        sl_cmd   = SL_NONE;
                        sl_count = 4'd0;
                        writes_done++;
                    end else begin
                        sl_count = sl_count + 4'd1;
                    end
                end
                SP_CONV1: begin
                    sl_crc   = crc_fold(sl_crc, bb);
                    sl_phase = SP_CONV2;
                end
                SP_CONV2: begin
                    sl_crc = crc_fold(sl_crc, bb);
                    queue_crc();
                    add_result(KIND_BIT, 8'h00);
                    add_result(KIND_BIT, 8'h01);
                    sl_phase = SP_IDLE;
                    sl_cmd   = SL_NONE;
                    converts_done++;
                end
                default: begin
                end
            endcase
        end
        n_out     = res_batch.size();
        first_out = 8'h00;
        if (n_out > 0) begin
            res_batch[n_out - 1].last = 1'b1;
            first_out = res_batch[0].value;
            foreach (res_batch[i]) begin
                expected_results.push_back(res_batch[i]);
            end
        end
    endtask

    // Offer one item, wait for it to be taken, predict, then idle per the burst pattern
    task automatic send_item(input logic [1:0] act, input logic [7:0] bb,
                             input logic [1:0] ch, input logic [15:0] cv,
                             output int n_out, output logic [7:0] first_out);
        int gap;
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_bus_byte      <= bb;
        i_channel       <= ch;
        i_channel_value <= cv;
        do begin
            @(posedge i_clk);
        end while (!in_take);
        items_offered++;
        if (!(act == ACT_NONE || (act == ACT_BUS && sl_phase == SP_IDLE))) begin
            items_counted++;
        end
        predict_slave(act, bb, ch, cv, n_out, first_out);
        if (flood_left > 0) begin
            flood_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic offer(input logic [1:0] act, input logic [7:0] bb);
        int         n;
        logic [7:0] f;
        send_item(act, bb, 2'($urandom), 16'($urandom), n, f);
    endtask

    // Mostly legal page addresses, some right at the boundary, some anywhere
    task automatic offer_address;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            offer(ACT_BUS, 8'($urandom_range(0, LAST_START)));
            offer(ACT_BUS, 8'h00);
        end else if (r < 8) begin
            offer(ACT_BUS, 8'(LAST_START) + 8'($urandom_range(0, 1)));
            offer(ACT_BUS, 8'h00);
        end else begin
            offer(ACT_BUS, 8'($urandom));
            offer(ACT_BUS, 8'($urandom));
        end
    endtask

    task automatic random_transaction;
        int         pick;
        int         cut;
        logic [7:0] cmd_b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            offer(ACT_START, 8'($urandom));
            offer(ACT_BUS, CMD_READ);
            offer_address();
        end else if (pick < 55) begin
            offer(ACT_START, 8'($urandom));
            offer(ACT_BUS, CMD_WRITE);
            offer_address();
            for (int k = 0; k < PAGE_BYTES; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    offer(ACT_HOST, 8'($urandom));
                end
                offer(ACT_BUS, 8'($urandom));
            end
        end else if (pick < 75) begin
            offer(ACT_START, 8'($urandom));
            offer(ACT_BUS, CMD_CONVERT);
            offer(ACT_BUS, 8'($urandom));
            offer(ACT_BUS, 8'($urandom));
        end else if (pick < 85) begin
            offer(ACT_HOST, 8'($urandom));
        end else if (pick < 90) begin
            do begin
                cmd_b = 8'($urandom);
            end while (cmd_b == CMD_READ || cmd_b == CMD_WRITE || cmd_b == CMD_CONVERT);
            offer(ACT_START, 8'($urandom));
            offer(ACT_BUS, cmd_b);
        end else if (pick < 95) begin
            offer(($urandom_range(0, 1) == 0) ? ACT_NONE : ACT_BUS, 8'($urandom));
        end else begin
            // cut a command short; the next start lands mid-command
            offer(ACT_START, 8'($urandom));
            case ($urandom_range(0, 2))
                0:       cmd_b = CMD_READ;
                1:       cmd_b = CMD_WRITE;
                default: cmd_b = CMD_CONVERT;
            endcase
            offer(ACT_BUS, cmd_b);
            cut = $urandom_range(0, 2);
            repeat (cut) offer(ACT_BUS, 8'($urandom));
        end
    endtask

    // Sample at the falling edge: values are settled and hold until the next rising edge
    always @(negedge i_clk) begin
        in_take <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing expected: kind %0d value %02h last %0d",
                                        o_kind, o_out_value, o_last));
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_kind !== want.kind) begin
                    flag_mismatch($sformatf("result %0d kind %0d, want %0d",
                                            results_checked, o_kind, want.kind));
                end
                if (o_out_value !== want.value) begin
                    flag_mismatch($sformatf("result %0d value %02h, want %02h",
                                            results_checked, o_out_value, want.value));
                end
                if (o_last !== want.last) begin
                    flag_mismatch($sformatf("result %0d last %0d, want %0d",
                                            results_checked, o_last, want.last));
                end
            end
        end
    end

    // Receiver: rotate through stall patterns; a requested hold-off overrides them
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 32'd1;
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_ready  <= 1'b0;
        end else if (hold_off_asked != hold_off_given) begin
            hold_off_given <= hold_off_asked;
            rx_hold_left   <= HOLD_OFF_CYCLES;
            i_out_ready    <= 1'b0;
        end else begin
            case (rx_cycle[8:7])
                2'd0:    i_out_ready <= 1'b1;
                2'd1:    i_out_ready <= ($urandom_range(0, 1) == 1);
                2'd2:    i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (rx_cycle[2:0] < 3'd3);
            endcase
        end
    end

    initial begin
        int         n_got;
        int         guard;
        logic [7:0] first_got;
        bit         hold_off_sent;
        hold_off_sent = 1'b0;
        for (int i = 0; i < MEM_BYTES; i++) begin
            sl_mem[i] = 8'h00;
        end
        if (MEM_BYTES > INIT_IDX) begin
            sl_mem[INIT_IDX] = INIT_VAL;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(dir_rows[r].act, dir_rows[r].bus_b, dir_rows[r].chan, dir_rows[r].chval,
                      n_got, first_got);
            if (n_got != int'(dir_rows[r].n_exp)) begin
                flag_mismatch($sformatf("directed row %0d gives %0d results, table has %0d",
                                        r, n_got, dir_rows[r].n_exp));
            end
            if (dir_rows[r].first_typed && n_got > 0 && first_got != dir_rows[r].first_val) begin
                flag_mismatch($sformatf("directed row %0d first byte %02h, table has %02h",
                                        r, first_got, dir_rows[r].first_val));
            end
        end

        while (items_counted < ITEMS_TARGET) begin
            if (!hold_off_sent && items_counted >= HOLD_OFF_AT) begin
                // keep offering back to back while the receiver sits still
                hold_off_asked <= hold_off_asked + 1;
                flood_left    = FLOOD_ITEMS;
                hold_off_sent = 1'b1;
            end
            random_transaction();
        end
        i_in_valid <= 1'b0;

        guard = 0;
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    expected_results.size()));
        end

        $display("Run offered %0d items (%0d acted on) and checked %0d results.",
                 items_offered, items_counted, results_checked);
        $display("It completed %0d page reads, %0d page writes, %0d conversions, %0d mismatches.",
                 reads_done, writes_done, converts_done, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
